@@ design/tkbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tkbd_pkg
// Shared widths, constants and types of the touch key baseline detector.
// ----------------------------------------------------------------------------
package tkbd_pkg;

	localparam int CH_W        = 4;
	localparam int SAMPLE_W    = 16;
	localparam int SUM_W       = 24;
	localparam int CALIB_W     = 8;
	localparam int ENABLE_W    = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int DIV_STEPS   = SUM_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam int CHANNELS_DEF    = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_SCANS    = 1'b1;

	localparam logic [ENABLE_W-1:0] ENABLE_RESET = 16'h00f0;
	localparam logic [CALIB_W-1:0]  CALIB_RESET  = 8'd50;
	localparam logic [SUM_W-1:0]    SUM_MAX      = '1;

	// what the back end does with a request
	typedef enum logic [1:0] {
		OP_PASS,
		OP_ACCUM,
		OP_JUDGE
	} tkbd_op_t;

	typedef struct packed {
		tkbd_op_t              op;
		logic [CH_W-1:0]       channel;
		logic [SAMPLE_W-1:0]   sample;
		logic                  cal;
	} tkbd_entry_t;

	typedef struct packed {
		logic                  start;
		logic [SUM_W-1:0]      dividend;
		logic [CALIB_W-1:0]    divisor;
	} tkbd_div_req_t;

	typedef struct packed {
		logic                  done;
		logic [SUM_W-1:0]      quotient;
	} tkbd_div_rsp_t;

endpackage
`default_nettype wire

@@ design/tkbd_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tkbd_in_if
// Sample channel: one touch-scan sample per request.
// ----------------------------------------------------------------------------
interface tkbd_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  channel;
	logic [15:0] sample;
	logic        end_of_scan;

	modport source (output valid, output channel, output sample, output end_of_scan,
		input ready);
	modport sink (input valid, input channel, input sample, input end_of_scan,
		output ready);
endinterface
`default_nettype wire

@@ design/tkbd_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tkbd_out_if
// Result channel: one judgement per sample.
// ----------------------------------------------------------------------------
interface tkbd_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] result_channel;
	logic       touched;
	logic       calibrating;

	modport source (output valid, output result_channel, output touched,
		output calibrating, input ready);
	modport sink (input valid, input result_channel, input touched,
		input calibrating, output ready);
endinterface
`default_nettype wire

@@ design/tkbd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tkbd_front
// Accepts samples, tracks the calibration phase and classifies each request.
// ----------------------------------------------------------------------------
module tkbd_front #(
	parameter int CHANNELS    = tkbd_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = tkbd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	tkbd_in_if.sink                                sample_ch,
	input  wire logic [tkbd_pkg::ENABLE_W-1:0]     channel_enable,
	input  wire logic [tkbd_pkg::CALIB_W-1:0]      calib_scans,
	input  wire logic                              push_ready,
	output logic                                   push_valid,
	output tkbd_pkg::tkbd_entry_t                  push_entry
);
	import tkbd_pkg::*;

	localparam int SAMPLE_KEEP = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
		SAMPLE_W'((33'd1 << SAMPLE_KEEP) - 33'd1);

	logic [CALIB_W-1:0] scans_done_q;
	logic               detect_phase_q;
	logic [CALIB_W-1:0] scans_next;
	logic               ch_on;
	logic               cal;
	logic               accept;

	assign sample_ch.ready = push_ready;
	assign push_valid      = sample_ch.valid;
	assign accept          = sample_ch.valid && push_ready;

	assign cal        = !detect_phase_q;
	assign ch_on      = ({1'b0, sample_ch.channel} < (CH_W + 1)'(CHANNELS))
		&& channel_enable[sample_ch.channel];
	assign scans_next = scans_done_q + CALIB_W'(1);

	always_comb begin
		push_entry.channel = sample_ch.channel;
		push_entry.sample  = sample_ch.sample & SAMPLE_MASK;
		push_entry.cal     = cal;
		priority if (!ch_on) begin
			push_entry.op = OP_PASS;
		end else if (cal) begin
			push_entry.op = OP_ACCUM;
		end else begin
			push_entry.op = OP_JUDGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scans_done_q   <= '0;
			detect_phase_q <= 1'b0;
		end else if (accept && cal && sample_ch.end_of_scan) begin
			scans_done_q <= scans_next;
			// a zero register value also ends calibration after one scan
			if (scans_next >= calib_scans) begin
				detect_phase_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/tkbd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tkbd_queue
// Two-entry request queue between the front and the back end.
// ----------------------------------------------------------------------------
module tkbd_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push_valid,
	input  wire tkbd_pkg::tkbd_entry_t push_entry,
	output logic                       push_ready,
	input  wire logic                  pop,
	output logic                       pop_valid,
	output tkbd_pkg::tkbd_entry_t      pop_entry
);
	import tkbd_pkg::*;

	localparam int DEPTH = 2;

	tkbd_entry_t entries_q [DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = (count_q != 2'(DEPTH));
	assign pop_valid  = (count_q != 2'd0);
	assign pop_entry  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/tkbd_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tkbd_div
// Restoring divider, one quotient bit per cycle, for the channel baseline.
// ----------------------------------------------------------------------------
module tkbd_div (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tkbd_pkg::tkbd_div_req_t req,
	output tkbd_pkg::tkbd_div_rsp_t     rsp
);
	import tkbd_pkg::*;

	logic [CALIB_W-1:0]   rem_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CALIB_W-1:0]   div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CALIB_W:0]     shifted;
	logic [CALIB_W:0]     diff;
	logic                 fits;

	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign fits    = (shifted >= {1'b0, div_q});

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= CALIB_W'(1);
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (req.start) begin
				rem_q  <= '0;
				quo_q  <= req.dividend;
				// zero count divides by one
				div_q  <= (req.divisor == '0) ? CALIB_W'(1) : req.divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// remainder stays below the divisor, so it fits the narrow register
				rem_q <= fits ? diff[CALIB_W-1:0] : shifted[CALIB_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], fits};
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ design/tkbd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tkbd_back
// Executes requests: sum accumulation, baseline divide, window compare.
// ----------------------------------------------------------------------------
module tkbd_back #(
	parameter int CHANNELS = tkbd_pkg::CHANNELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [tkbd_pkg::CALIB_W-1:0]  calib_scans,
	input  wire logic                          pop_valid,
	input  wire tkbd_pkg::tkbd_entry_t         pop_entry,
	output logic                               pop,
	tkbd_out_if.source                         result_ch
);
	import tkbd_pkg::*;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PROD_W   = SUM_W + 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_RESULT
	} state_t;

	state_t             state_q;
	tkbd_entry_t        ent_q;
	logic               touched_q;
	logic [SUM_W-1:0]   sums_q [CHANNELS];
	logic               out_valid_q;
	logic [CH_W-1:0]    out_channel_q;
	logic               out_touched_q;
	logic               out_cal_q;

	tkbd_div_req_t      div_req;
	tkbd_div_rsp_t      div_rsp;

	logic [CH_IDX_W-1:0] idx;
	logic [SUM_W:0]      sum_add;
	logic [SUM_W-1:0]    sum_sat;
	logic [PROD_W-1:0]   s10;
	logic [PROD_W-1:0]   base_ext;
	logic [PROD_W-1:0]   base6;
	logic                in_window;
	logic                out_free;

	assign idx     = ent_q.channel[CH_IDX_W-1:0];
	assign sum_add = {1'b0, sums_q[idx]} + (SUM_W + 1)'(ent_q.sample);
	assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

	// 10*s and 6*base by shift and add
	assign s10      = (PROD_W'(ent_q.sample) << 3) + (PROD_W'(ent_q.sample) << 1);
	assign base_ext = PROD_W'(div_rsp.quotient);
	assign base6    = (base_ext << 2) + (base_ext << 1);
	assign in_window = (s10 < base6) && (s10 > base_ext);

	assign div_req.start    = (state_q == ST_EXEC) && (ent_q.op == OP_JUDGE);
	assign div_req.dividend = sums_q[idx];
	assign div_req.divisor  = calib_scans;

	tkbd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign pop      = (state_q == ST_IDLE) && pop_valid;
	assign out_free = !out_valid_q || result_ch.ready;

	assign result_ch.valid          = out_valid_q;
	assign result_ch.result_channel = out_channel_q;
	assign result_ch.touched        = out_touched_q;
	assign result_ch.calibrating    = out_cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ent_q         <= '0;
			touched_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_channel_q <= '0;
			out_touched_q <= 1'b0;
			out_cal_q     <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			// the result state reloads the output register itself
			if (out_valid_q && result_ch.ready && (state_q != ST_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						ent_q   <= pop_entry;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					touched_q <= 1'b0;
					unique case (ent_q.op)
						OP_ACCUM: begin
							sums_q[idx] <= sum_sat;
							state_q     <= ST_RESULT;
						end
						OP_JUDGE: state_q <= ST_DIV;
						default:  state_q <= ST_RESULT;
					endcase
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						touched_q <= in_window;
						state_q   <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_channel_q <= ent_q.channel;
						out_touched_q <= touched_q;
						out_cal_q     <= ent_q.cal;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/touch_key_baseline_detector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// touch_key_baseline_detector
// Capacitive touch detection against a calibrated per-channel baseline.
// ----------------------------------------------------------------------------
// Every sample request yields one result, in order. For the first calib_scans
// scans the sums of enabled channels are accumulated and results report
// calibrating; after that a sample of an enabled channel is touched when
// 10*sample lies below 6*baseline and above baseline, baseline being the
// channel sum divided by calib_scans. A calibration or disabled-channel sample
// passes the back end's idle, execute and result states; a detection sample
// adds the divide state, where the divider forms the baseline one quotient bit
// per cycle over the 24-bit sum. A two-entry queue keeps the front accepting
// samples while the back end divides or a result sits in the output register.
// ----------------------------------------------------------------------------
module touch_key_baseline_detector #(
	parameter int CHANNELS    = tkbd_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = tkbd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	tkbd_in_if.sink                                 sample_ch,
	tkbd_out_if.source                              result_ch,
	input  wire logic                               cfg_we,
	input  wire logic [tkbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tkbd_pkg::CFG_W-1:0]         cfg_wdata
);
	import tkbd_pkg::*;

	logic [ENABLE_W-1:0] channel_enable_q;
	logic [CALIB_W-1:0]  calib_scans_q;

	logic                push_valid;
	logic                push_ready;
	tkbd_entry_t         push_entry;
	logic                pop;
	logic                pop_valid;
	tkbd_entry_t         pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_enable_q <= ENABLE_RESET;
			calib_scans_q    <= CALIB_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNEL_ENABLE: channel_enable_q <= cfg_wdata[ENABLE_W-1:0];
				REG_CALIB_SCANS:    calib_scans_q    <= cfg_wdata[CALIB_W-1:0];
				default:            calib_scans_q    <= calib_scans_q;
			endcase
		end
	end

	tkbd_front #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_ch      (sample_ch),
		.channel_enable (channel_enable_q),
		.calib_scans    (calib_scans_q),
		.push_ready     (push_ready),
		.push_valid     (push_valid),
		.push_entry     (push_entry)
	);

	tkbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry)
	);

	tkbd_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.calib_scans (calib_scans_q),
		.pop_valid   (pop_valid),
		.pop_entry   (pop_entry),
		.pop         (pop),
		.result_ch   (result_ch)
	);

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the touch key baseline detector. A calibration run
// fills the channel sums (one channel driven into saturation), a zero scan
// count closes calibration, and detection phases then probe the touch window
// edges under a range of enable masks and scan counts. Every result is
// checked in order against a running model of sums, scan count and phase.
// ----------------------------------------------------------------------------
module tb_top;
	import tkbd_pkg::*;

	localparam int CH_COUNT    = 16;
	localparam int TAIL_CYCLES = 64;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic            touched;
		logic            calibrating;
	} verdict_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	tkbd_in_if  sample_bus();
	tkbd_out_if result_bus();

	touch_key_baseline_detector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_bus),
		.result_ch (result_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// running copy of the detector state
	logic [ENABLE_W-1:0] enable_mask;
	logic [CALIB_W-1:0]  scan_divisor;
	logic [SUM_W-1:0]    chan_sum [CH_COUNT];
	logic [CALIB_W-1:0]  scans_seen;
	logic                detecting;

	int unsigned level [CH_COUNT];
	verdict_t    pending_verdicts[$];
	int          mismatch_count = 0;
	int          hold_off_left  = 0;
	bit          no_idle        = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("touch_key_baseline_detector test failed");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return $urandom_range(1, 2);
		end else if (r < 90) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic longint unsigned divisor_now();
		return (scan_divisor == 0) ? 1 : scan_divisor;
	endfunction

	function automatic verdict_t judge_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] s,
		logic eos);
		verdict_t          v;
		logic [SUM_W:0]    acc;
		longint unsigned   base;
		longint unsigned   s10;
		v.channel     = ch;
		v.touched     = 1'b0;
		v.calibrating = !detecting;
		if (!detecting) begin
			if (enable_mask[ch]) begin
				acc = {1'b0, chan_sum[ch]} + (SUM_W + 1)'(s);
				chan_sum[ch] = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
			end
			if (eos) begin
				scans_seen = scans_seen + CALIB_W'(1);
				if (scans_seen >= scan_divisor) detecting = 1'b1;
			end
		end else if (enable_mask[ch]) begin
			base = chan_sum[ch] / divisor_now();
			s10  = s;
			s10  = s10 * 10;
			v.touched = (s10 < base * 6) && (s10 > base);
		end
		return v;
	endfunction

	// sample aimed at the touch window of the channel's current baseline
	function automatic logic [SAMPLE_W-1:0] touch_probe(logic [CH_W-1:0] ch);
		longint unsigned base;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned pick;
		base = chan_sum[ch] / divisor_now();
		lo   = base / 10;
		hi   = (base * 6) / 10;
		case ($urandom_range(0, 5))
			0: pick = lo + $urandom_range(0, 1);
			1: pick = (hi > 0) ? hi - 1 + $urandom_range(0, 2) : $urandom_range(0, 1);
			2, 3: pick = (hi > lo + 1) ? lo + 1 + ($urandom % (hi - lo)) : lo;
			4: pick = base + $urandom_range(0, 3);
			default: pick = $urandom_range(0, 1) ? 0 : 16'hffff;
		endcase
		if (pick > 16'hffff) pick = $urandom_range(0, 16'hffff);
		return pick[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] calib_sample(logic [CH_W-1:0] ch);
		longint v;
		if ($urandom_range(0, 9) == 0) return SAMPLE_W'($urandom_range(0, 16'hffff));
		v = longint'(level[ch]) + $urandom_range(0, 512) - 256;
		if (v < 0) v = 0;
		if (v > 16'hffff) v = 16'hffff;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic send_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] s, logic eos);
		int gap;
		gap = (no_idle || $urandom_range(0, 1)) ? 0 : idle_len();
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid       <= 1'b1;
		sample_bus.channel     <= ch;
		sample_bus.sample      <= s;
		sample_bus.end_of_scan <= eos;
		do @(posedge clk); while (!sample_bus.ready);
		pending_verdicts.push_back(judge_sample(ch, s, eos));
	endtask

	task automatic wait_idle();
		sample_bus.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (idx == REG_CHANNEL_ENABLE) begin
			enable_mask = data[ENABLE_W-1:0];
		end else begin
			scan_divisor = data[CALIB_W-1:0];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [ENABLE_W-1:0] enable, logic [CALIB_W-1:0] calib);
		wait_idle();
		write_reg(REG_CHANNEL_ENABLE, enable);
		write_reg(REG_CALIB_SCANS, {{(CFG_W-CALIB_W){1'b0}}, calib});
	endtask

	// one calibration scan, most of it full-scale on channel 0 to saturate its sum
	task automatic run_calib_scan(int n);
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] s;
		for (int i = 0; i < n; i++) begin
			no_idle = ((i / 40) % 3 == 2);
			ch = (i % 8 != 7) ? '0 : CH_W'($urandom_range(1, 15));
			s  = (ch == 0) ? 16'hffff : calib_sample(ch);
			send_sample(ch, s, i == n - 1);
		end
		no_idle = 1'b0;
	endtask

	// reset settings: only channels 4..7 accumulate
	task automatic test_reset_calibration();
		for (int c = 0; c < CH_COUNT; c++) begin
			send_sample(c[CH_W-1:0], c[0] ? 16'hffff : 16'h0000, c == CH_COUNT - 1);
		end
	endtask

	task automatic test_disabled_calibration();
		set_config(16'h0000, 8'd255);
		send_sample(4'd0, 16'h5a5a, 1'b0);
		send_sample(4'd15, 16'ha5a5, 1'b0);
		send_sample(4'd9, SAMPLE_W'($urandom_range(0, 16'hffff)), 1'b1);
	endtask

	task automatic test_saturation_scans();
		for (int c = 0; c < CH_COUNT; c++) level[c] = $urandom_range(300, 60000);
		set_config(16'hffff, 8'd200);
		run_calib_scan(150);
		set_config(ENABLE_W'($urandom_range(0, 16'hffff)) | 16'h0001, 8'd200);
		run_calib_scan(150);
	endtask

	// zero scan count: the next end of scan closes calibration
	task automatic test_zero_calib_end();
		logic [CH_W-1:0] ch;
		set_config(16'hffff, 8'd0);
		for (int i = 0; i < 8; i++) begin
			ch = CH_W'(2 * i + 1);
			send_sample(ch, calib_sample(ch), i == 7);
		end
	endtask

	task automatic test_divide_by_one();
		logic [CH_W-1:0] ch;
		send_sample(4'd3, 16'h0000, 1'b1);
		send_sample(4'd3, 16'hffff, 1'b0);
		for (int i = 0; i < 10; i++) begin
			ch = CH_W'($urandom_range(0, 15));
			send_sample(ch, touch_probe(ch), i[0]);
		end
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_full_queue_stall();
		logic [CH_W-1:0] ch;
		hold_off_left = 300;
		no_idle       = 1'b1;
		for (int i = 0; i < 16; i++) begin
			ch = CH_W'($urandom_range(0, 15));
			send_sample(ch, touch_probe(ch), 1'($urandom_range(0, 1)));
		end
		no_idle = 1'b0;
	endtask

	task automatic test_detection_random();
		logic [ENABLE_W-1:0] enable;
		logic [CALIB_W-1:0]  calib;
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] s;
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin enable = 16'hffff; calib = 8'd4;   end
				1: begin enable = 16'h0000; calib = 8'd1;   end
				2: begin enable = ENABLE_W'($urandom_range(0, 16'hffff)); calib = 8'd255; end
				3: begin enable = 16'hffff; calib = 8'd1;   end
				default: begin
					enable = ENABLE_W'($urandom_range(0, 16'hffff));
					calib  = CALIB_W'($urandom_range(0, 255));
				end
			endcase
			set_config(enable, calib);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 25; i++) begin
				ch = CH_W'($urandom_range(0, 15));
				s  = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom_range(0, 16'hffff))
					: touch_probe(ch);
				send_sample(ch, s, 1'($urandom_range(0, 1)));
			end
		end
		no_idle = 1'b0;
	endtask

	// result side: random stalls, plus the long hold-off when one is requested
	initial begin
		int stall_left;
		stall_left = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				result_bus.ready <= 1'b0;
				hold_off_left--;
			end else if (stall_left > 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				result_bus.ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_len();
			end
		end
	end

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("mismatch: %s", msg);
	endfunction

	initial begin
		verdict_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid === 1'b1 && result_bus.ready) begin
				if (pending_verdicts.size() == 0) begin
					note_mismatch($sformatf("result for channel %0d with none expected",
						result_bus.result_channel));
				end else begin
					want = pending_verdicts.pop_front();
					if (result_bus.result_channel !== want.channel)
						note_mismatch($sformatf("result_channel expected %0d got %0d",
							want.channel, result_bus.result_channel));
					if (result_bus.touched !== want.touched)
						note_mismatch($sformatf("ch %0d touched expected %0b got %0b",
							want.channel, want.touched, result_bus.touched));
					if (result_bus.calibrating !== want.calibrating)
						note_mismatch($sformatf("ch %0d calibrating expected %0b got %0b",
							want.channel, want.calibrating, result_bus.calibrating));
				end
			end
		end
	end

	initial begin
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= REG_CHANNEL_ENABLE;
		cfg_wdata              <= '0;
		sample_bus.valid       <= 1'b0;
		sample_bus.channel     <= '0;
		sample_bus.sample      <= '0;
		sample_bus.end_of_scan <= 1'b0;
		enable_mask  = ENABLE_RESET;
		scan_divisor = CALIB_RESET;
		scans_seen   = '0;
		detecting    = 1'b0;
		foreach (chan_sum[c]) chan_sum[c] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_calibration();
		test_disabled_calibration();
		test_saturation_scans();
		test_zero_calib_end();
		test_divide_by_one();
		test_full_queue_stall();
		test_detection_random();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
			$display("touch_key_baseline_detector test passed");
		end else begin
			$display("touch_key_baseline_detector test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/tkbd_pkg.sv
design/tkbd_in_if.sv
design/tkbd_out_if.sv
design/tkbd_front.sv
design/tkbd_queue.sv
design/tkbd_div.sv
design/tkbd_back.sv
design/touch_key_baseline_detector.sv
tb/tb_top.sv
